FILE: src/cpose_pkg.sv
package cpose_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int ANG_SHIFT    = 24 - FRAC_BITS;
   localparam int VEC_SHIFT    = 30 - FRAC_BITS;
   localparam int SQ_W         = 38;
   localparam int SQRT_ITERS   = SQ_W / 2;
   localparam int DIV_ITERS    = FRAC_BITS + 1;

   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [33:0] ANG_RIGHT   = 34'sd90 <<< 24;
   localparam logic signed [33:0] ANG_HALF    = 34'sd180 <<< 24;
   localparam logic signed [25:0] DEG89       = 26'sd89 <<< FRAC_BITS;
   localparam logic signed [25:0] DEG180      = 26'sd180 <<< FRAC_BITS;
   localparam logic signed [25:0] DEG360      = 26'sd360 <<< FRAC_BITS;
   localparam logic signed [17:0] ONE_Q       = 18'sd1 <<< FRAC_BITS;

   localparam logic [2:0] REG_SPEED = 3'd0;
   localparam logic [2:0] REG_LOCK  = 3'd1;
   localparam logic [2:0] REG_UP_X  = 3'd2;
   localparam logic [2:0] REG_UP_Y  = 3'd3;
   localparam logic [2:0] REG_UP_Z  = 3'd4;

   localparam logic [1:0] OP_REL   = 2'd0;
   localparam logic [1:0] OP_AXIS  = 2'd1;
   localparam logic [1:0] OP_PLANE = 2'd2;
   localparam logic [1:0] OP_ROT   = 2'd3;

   localparam logic [1:0] DIR_FWD   = 2'd0;
   localparam logic [1:0] DIR_BACK  = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_DIST, DP_DSEL, DP_CROSS, DP_SQ, DP_SQRT_INIT, DP_SQRT,
      DP_DIV_INIT, DP_DIV, DP_DIV_DONE, DP_UNIT_ZERO, DP_UNIT_FWD, DP_MOVE,
      DP_ROT, DP_CINIT, DP_CSTEP, DP_CDONE, DP_BUILD, DP_FWD, DP_APPLY, DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] idx;
      logic [1:0] sub;
      logic [4:0] step;
      logic       sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] dir;
      logic       len_zero;
   } dp_stat_type;

   function automatic logic [1:0] nxt1(input logic [1:0] i);
      logic [1:0] r;
      unique case (i)
         2'd0: r = 2'd1;
         2'd1: r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] nxt2(input logic [1:0] i);
      logic [1:0] r;
      unique case (i)
         2'd0: r = 2'd2;
         2'd1: r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
      logic signed [33:0] r;
      unique case (i)
         5'd0:  r = 34'sd754974720;
         5'd1:  r = 34'sd445687602;
         5'd2:  r = 34'sd235489088;
         5'd3:  r = 34'sd119537938;
         5'd4:  r = 34'sd60000934;
         5'd5:  r = 34'sd30029717;
         5'd6:  r = 34'sd15018523;
         5'd7:  r = 34'sd7509720;
         5'd8:  r = 34'sd3754917;
         5'd9:  r = 34'sd1877466;
         5'd10: r = 34'sd938734;
         5'd11: r = 34'sd469367;
         5'd12: r = 34'sd234684;
         5'd13: r = 34'sd117342;
         5'd14: r = 34'sd58671;
         5'd15: r = 34'sd29335;
         5'd16: r = 34'sd14668;
         5'd17: r = 34'sd7334;
         5'd18: r = 34'sd3667;
         5'd19: r = 34'sd1833;
         5'd20: r = 34'sd917;
         5'd21: r = 34'sd458;
         5'd22: r = 34'sd229;
         5'd23: r = 34'sd115;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/cpose_ctrl.sv
module cpose_ctrl import cpose_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DIST, S_DSEL, S_CROSS, S_SQ, S_SQRT_INIT, S_SQRT, S_LEN,
      S_DIV_INIT, S_DIV, S_DIV_DONE, S_UNIT_ZERO, S_UNIT_FWD, S_MOVE,
      S_ROT, S_CINIT, S_CSTEP, S_CDONE, S_BUILD, S_FWD, S_APPLY, S_OUT
   } state_type;

   state_type  state_ff;
   logic [1:0] idx_ff;
   logic [1:0] sub_ff;
   logic [4:0] step_ff;
   logic       sel_ff;
   logic       rotm_ff;
   logic       rsp_valid_ff;
   logic       out_load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cmd.idx  = idx_ff;
      cmd.sub  = sub_ff;
      cmd.step = step_ff;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         S_IDLE:      cmd.op = req_tvalid ? DP_LOAD : DP_NOP;
         S_DIST:      cmd.op = DP_DIST;
         S_DSEL:      cmd.op = DP_DSEL;
         S_CROSS:     cmd.op = DP_CROSS;
         S_SQ:        cmd.op = DP_SQ;
         S_SQRT_INIT: cmd.op = DP_SQRT_INIT;
         S_SQRT:      cmd.op = DP_SQRT;
         S_LEN:       cmd.op = DP_NOP;
         S_DIV_INIT:  cmd.op = DP_DIV_INIT;
         S_DIV:       cmd.op = DP_DIV;
         S_DIV_DONE:  cmd.op = DP_DIV_DONE;
         S_UNIT_ZERO: cmd.op = DP_UNIT_ZERO;
         S_UNIT_FWD:  cmd.op = DP_UNIT_FWD;
         S_MOVE:      cmd.op = DP_MOVE;
         S_ROT:       cmd.op = DP_ROT;
         S_CINIT:     cmd.op = DP_CINIT;
         S_CSTEP:     cmd.op = DP_CSTEP;
         S_CDONE:     cmd.op = DP_CDONE;
         S_BUILD:     cmd.op = DP_BUILD;
         S_FWD:       cmd.op = DP_FWD;
         S_APPLY:     cmd.op = DP_APPLY;
         S_OUT:       cmd.op = out_load ? DP_OUT : DP_NOP;
         default:     cmd.op = DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         sub_ff       <= '0;
         step_ff      <= '0;
         sel_ff       <= 1'b0;
         rotm_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_DIST;
               end
            end
            S_DIST: state_ff <= S_DSEL;
            S_DSEL: begin
               idx_ff <= '0;
               sub_ff <= '0;
               if (stat.opcode == OP_ROT) begin
                  state_ff <= S_ROT;
               end else if (stat.opcode == OP_AXIS) begin
                  state_ff <= S_APPLY;
               end else if (stat.dir == DIR_FWD || stat.dir == DIR_BACK) begin
                  state_ff <= S_UNIT_FWD;
               end else begin
                  rotm_ff  <= 1'b0;
                  state_ff <= S_CROSS;
               end
            end
            S_CROSS: begin
               if (sub_ff == 2'd2) begin
                  sub_ff <= '0;
                  if (idx_ff == 2'd2) begin
                     idx_ff   <= '0;
                     state_ff <= S_SQ;
                  end else begin
                     idx_ff <= idx_ff + 2'd1;
                  end
               end else begin
                  sub_ff <= sub_ff + 2'd1;
               end
            end
            S_SQ: begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_ff <= S_SQRT_INIT;
               end
            end
            S_SQRT_INIT: begin
               step_ff  <= '0;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(SQRT_ITERS - 1)) begin
                  state_ff <= S_LEN;
               end
            end
            S_LEN: begin
               idx_ff <= '0;
               if (!stat.len_zero) begin
                  state_ff <= S_DIV_INIT;
               end else if (rotm_ff) begin
                  state_ff <= S_FWD;
               end else begin
                  state_ff <= S_UNIT_ZERO;
               end
            end
            S_DIV_INIT: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(DIV_ITERS - 1)) begin
                  state_ff <= S_DIV_DONE;
               end
            end
            S_DIV_DONE: begin
               if (idx_ff != 2'd2) begin
                  idx_ff   <= idx_ff + 2'd1;
                  state_ff <= S_DIV_INIT;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= rotm_ff ? S_FWD : S_MOVE;
               end
            end
            S_UNIT_ZERO: state_ff <= S_MOVE;
            S_UNIT_FWD:  state_ff <= S_MOVE;
            S_MOVE: begin
               idx_ff <= idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  state_ff <= S_APPLY;
               end
            end
            S_ROT: begin
               sel_ff   <= 1'b0;
               rotm_ff  <= 1'b1;
               state_ff <= S_CINIT;
            end
            S_CINIT: begin
               step_ff  <= '0;
               state_ff <= S_CSTEP;
            end
            S_CSTEP: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= S_CDONE;
               end
            end
            S_CDONE: begin
               idx_ff <= '0;
               if (!sel_ff) begin
                  sel_ff   <= 1'b1;
                  state_ff <= S_CINIT;
               end else begin
                  state_ff <= S_BUILD;
               end
            end
            S_BUILD: begin
               if (idx_ff == 2'd2) begin
                  idx_ff   <= '0;
                  state_ff <= S_SQ;
               end else begin
                  idx_ff <= idx_ff + 2'd1;
               end
            end
            S_FWD:   state_ff <= S_APPLY;
            S_APPLY: state_ff <= S_OUT;
            S_OUT: begin
               if (out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: src/cpose_dpath.sv
module cpose_dpath import cpose_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   input  logic [31:0]  req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [22:0]  csr_wdata,
   output logic [199:0] rsp_tdata
);

   logic [1:0]         op_ff, dir_ff, plane_ff;
   logic               rot_ff, scaled_ff;
   logic signed [24:0] amount_ff;

   logic [22:0]        speed_ff;
   logic               lock_ff;
   logic signed [17:0] up_ff [3];

   logic signed [31:0] pos_ff [3];
   logic signed [17:0] fwd_ff [3];
   logic signed [24:0] pitch_ff, yaw_ff;

   logic signed [58:0] prod_ff;
   logic signed [39:0] acc_ff;
   logic signed [32:0] dist_ff;
   logic signed [35:0] m_ff [3];
   logic signed [18:0] vec_ff [3];
   logic signed [17:0] unit_ff [3];
   logic [SQ_W-1:0]    rem_ff, root_ff, bit_ff;
   logic [35:0]        num_ff, dsh_ff;
   logic [16:0]        q_ff;
   logic               neg_ff;
   logic signed [32:0] cx_ff, cy_ff;
   logic signed [33:0] cz_ff;
   logic               flip_ff;
   logic signed [18:0] cp_ff, sp_ff, cyw_ff, syw_ff;
   logic [199:0]       rsp_ff;

   logic signed [24:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [58:0] prod_w;
   logic signed [25:0] ang_sum, ang_clamp, ang_wrap;
   logic signed [33:0] z_init;
   logic               flip_init;
   logic signed [32:0] x_fin, y_fin;
   logic [SQ_W-1:0]    trial;
   logic signed [32:0] dist_s;
   logic signed [18:0] vsel;
   logic [18:0]        vabs;
   logic signed [36:0] psum [3];
   logic signed [31:0] pnext [3];

   assign stat.opcode   = op_ff;
   assign stat.dir      = dir_ff;
   assign stat.len_zero = (root_ff == '0);
   assign rsp_tdata     = rsp_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         DP_DIST: begin
            mul_a = amount_ff;
            mul_b = $signed({11'b0, speed_ff});
         end
         DP_CROSS: begin
            if (cmd.sub == 2'd0) begin
               mul_a = 25'(fwd_ff[nxt1(cmd.idx)]);
               mul_b = 34'(up_ff[nxt2(cmd.idx)]);
            end else begin
               mul_a = 25'(fwd_ff[nxt2(cmd.idx)]);
               mul_b = 34'(up_ff[nxt1(cmd.idx)]);
            end
         end
         DP_SQ: begin
            if (cmd.idx != 2'd3) begin
               mul_a = 25'(vec_ff[cmd.idx]);
               mul_b = 34'(vec_ff[cmd.idx]);
            end
         end
         DP_MOVE: begin
            if (cmd.idx != 2'd3) begin
               mul_a = 25'(unit_ff[cmd.idx]);
               mul_b = 34'(dist_ff);
            end
         end
         DP_BUILD: begin
            mul_a = 25'(cp_ff);
            mul_b = (cmd.idx == 2'd0) ? 34'(cyw_ff) : 34'(syw_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_w = 59'(mul_a) * 59'(mul_b);

   // angle update with optional pitch clamp and wrap
   always_comb begin
      ang_sum   = (rot_ff ? 26'(yaw_ff) : 26'(pitch_ff)) + 26'(amount_ff);
      ang_clamp = ang_sum;
      if (!rot_ff && lock_ff) begin
         if (ang_sum > DEG89) begin
            ang_clamp = DEG89;
         end else if (ang_sum < -DEG89) begin
            ang_clamp = -DEG89;
         end
      end
      ang_wrap = ang_clamp;
      if (ang_clamp < -DEG180) begin
         ang_wrap = ang_clamp + DEG360;
      end else if (ang_clamp > DEG180) begin
         ang_wrap = ang_clamp - DEG360;
      end
   end

   always_comb begin
      z_init    = (cmd.sel ? 34'(yaw_ff) : 34'(pitch_ff)) <<< ANG_SHIFT;
      flip_init = 1'b0;
      if (z_init > ANG_RIGHT) begin
         z_init    = z_init - ANG_HALF;
         flip_init = 1'b1;
      end else if (z_init < -ANG_RIGHT) begin
         z_init    = z_init + ANG_HALF;
         flip_init = 1'b1;
      end
      x_fin = flip_ff ? -cx_ff : cx_ff;
      y_fin = flip_ff ? -cy_ff : cy_ff;
   end

   always_comb begin
      trial  = root_ff + bit_ff;
      dist_s = scaled_ff ? 33'(prod_ff >>> FRAC_BITS) : 33'(amount_ff);
      vsel   = vec_ff[cmd.idx == 2'd3 ? 2'd0 : cmd.idx];
      vabs   = vsel[18] ? 19'(-vsel) : 19'(vsel);
      for (int i = 0; i < 3; i++) begin
         if (op_ff == OP_PLANE && plane_ff == 2'(i)) begin
            psum[i] = 37'(pos_ff[i]);
         end else begin
            psum[i] = 37'(pos_ff[i]) + 37'(m_ff[i]);
         end
         if (psum[i] > 37'sd2147483647) begin
            pnext[i] = 32'sh7fffffff;
         end else if (psum[i] < -37'sd2147483648) begin
            pnext[i] = 32'sh80000000;
         end else begin
            pnext[i] = 32'(psum[i]);
         end
      end
   end

   // configuration and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= 23'd163840;
         lock_ff  <= 1'b1;
         up_ff[0] <= '0;
         up_ff[1] <= ONE_Q;
         up_ff[2] <= '0;
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
         fwd_ff[0] <= ONE_Q;
         fwd_ff[1] <= '0;
         fwd_ff[2] <= '0;
         pitch_ff <= '0;
         yaw_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_SPEED: speed_ff <= csr_wdata;
               REG_LOCK:  lock_ff  <= csr_wdata[0];
               REG_UP_X:  up_ff[0] <= $signed(csr_wdata[17:0]);
               REG_UP_Y:  up_ff[1] <= $signed(csr_wdata[17:0]);
               REG_UP_Z:  up_ff[2] <= $signed(csr_wdata[17:0]);
               default:   ;
            endcase
         end
         unique case (cmd.op)
            DP_ROT: begin
               if (rot_ff) begin
                  yaw_ff <= 25'(ang_wrap);
               end else begin
                  pitch_ff <= 25'(ang_wrap);
               end
            end
            DP_FWD: begin
               if (root_ff == '0) begin
                  fwd_ff[0] <= ONE_Q;
                  fwd_ff[1] <= '0;
                  fwd_ff[2] <= '0;
               end else begin
                  fwd_ff <= unit_ff;
               end
            end
            DP_APPLY: pos_ff <= pnext;
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_w;
      unique case (cmd.op)
         DP_LOAD: begin
            op_ff     <= req_tuser[1:0];
            scaled_ff <= req_tuser[2];
            dir_ff    <= req_tdata[1:0];
            plane_ff  <= req_tdata[3:2];
            rot_ff    <= req_tdata[4];
            amount_ff <= $signed(req_tdata[29:5]);
         end
         DP_DSEL: begin
            dist_ff <= (dir_ff == DIR_BACK || dir_ff == DIR_LEFT) ? -dist_s : dist_s;
            for (int i = 0; i < 3; i++) begin
               m_ff[i] <= (op_ff == OP_AXIS && dir_ff == 2'(i)) ? 36'(dist_s) : '0;
            end
         end
         DP_CROSS: begin
            if (cmd.sub == 2'd1) begin
               acc_ff <= 40'(prod_ff);
            end else if (cmd.sub == 2'd2) begin
               vec_ff[cmd.idx] <= 19'((acc_ff - 40'(prod_ff)) >>> FRAC_BITS);
            end
         end
         DP_SQ: acc_ff <= (cmd.idx == 2'd0) ? '0 : acc_ff + 40'(prod_ff);
         DP_SQRT_INIT: begin
            rem_ff  <= acc_ff[SQ_W-1:0];
            root_ff <= '0;
            bit_ff  <= SQ_W'(1) << (SQ_W - 2);
         end
         DP_SQRT: begin
            if (rem_ff >= trial) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         DP_DIV_INIT: begin
            neg_ff <= vsel[18];
            num_ff <= 36'(vabs) << FRAC_BITS;
            dsh_ff <= 36'(root_ff[18:0]) << FRAC_BITS;
            q_ff   <= '0;
         end
         DP_DIV: begin
            if (num_ff >= dsh_ff) begin
               num_ff <= num_ff - dsh_ff;
               q_ff   <= {q_ff[15:0], 1'b1};
            end else begin
               q_ff <= {q_ff[15:0], 1'b0};
            end
            dsh_ff <= dsh_ff >> 1;
         end
         DP_DIV_DONE: begin
            if (cmd.idx != 2'd3) begin
               unit_ff[cmd.idx] <= neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
            end
         end
         DP_UNIT_ZERO: begin
            unit_ff[0] <= '0;
            unit_ff[1] <= '0;
            unit_ff[2] <= '0;
         end
         DP_UNIT_FWD: unit_ff <= fwd_ff;
         DP_MOVE: begin
            if (cmd.idx != 2'd0) begin
               m_ff[cmd.idx - 2'd1] <= 36'(prod_ff >>> FRAC_BITS);
            end
         end
         DP_CINIT: begin
            cx_ff   <= CORDIC_GAIN;
            cy_ff   <= '0;
            cz_ff   <= z_init;
            flip_ff <= flip_init;
         end
         DP_CSTEP: begin
            if (cz_ff >= 0) begin
               cx_ff <= cx_ff - (cy_ff >>> cmd.step);
               cy_ff <= cy_ff + (cx_ff >>> cmd.step);
               cz_ff <= cz_ff - atan_deg(cmd.step);
            end else begin
               cx_ff <= cx_ff + (cy_ff >>> cmd.step);
               cy_ff <= cy_ff - (cx_ff >>> cmd.step);
               cz_ff <= cz_ff + atan_deg(cmd.step);
            end
         end
         DP_CDONE: begin
            if (cmd.sel) begin
               cyw_ff <= 19'(x_fin >>> VEC_SHIFT);
               syw_ff <= 19'(y_fin >>> VEC_SHIFT);
            end else begin
               cp_ff <= 19'(x_fin >>> VEC_SHIFT);
               sp_ff <= 19'(y_fin >>> VEC_SHIFT);
            end
         end
         DP_BUILD: begin
            if (cmd.idx == 2'd1) begin
               vec_ff[0] <= 19'(prod_ff >>> FRAC_BITS);
            end else if (cmd.idx == 2'd2) begin
               vec_ff[2] <= 19'(prod_ff >>> FRAC_BITS);
               vec_ff[1] <= sp_ff;
            end
         end
         DP_OUT: begin
            rsp_ff <= {yaw_ff, pitch_ff, fwd_ff[2], fwd_ff[1], fwd_ff[0],
                       pos_ff[2], pos_ff[1], pos_ff[0]};
         end
         default: ;
      endcase
   end

endmodule

FILE: src/camera_pose_update_top.sv
// an item is accepted only in idle, once the last is in the output register
// the rotate path runs two cordic passes, a square root and three 17-step divisions
// a finished transaction waits in the output register while the next is taken
// synchronous active-high reset: pose at origin facing +x, registers at defaults
module camera_pose_update_top import cpose_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  req_tdata,   // direction, plane_axis, rotation_axis, amount
   input  logic [2:0]   req_tuser,   // opcode, scale_by_speed
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic [199:0] rsp_tdata,   // pos_x, pos_y, pos_z, front_x, front_y, front_z,
                                     // pitch_deg, yaw_deg
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [22:0]  csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   cpose_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cpose_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

FILE: sim/camera_pose_update_checker.sv
module camera_pose_update_checker import cpose_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [31:0]  req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [199:0] rsp_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [22:0]  csr_wdata,
   output int           fail_count,
   output int           pending,
   output int           checked
);

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [17:0] fx, fy, fz;
      logic signed [24:0] pitch, yaw;
   } pose_type;

   pose_type pose_q[$];

   longint speed_r, lock_r;
   longint up_v[3];
   longint pos_v[3];
   longint fwd_v[3];
   longint pitch_r, yaw_r;

   localparam longint ONE = 64'sd1 <<< FRAC_BITS;

   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit unit_vec(input longint a, b, c, output longint oa, ob, oc);
      longint unsigned s;
      longint len;
      s = longint'(a * a) + longint'(b * b) + longint'(c * c);
      len = longint'(isqrt(s));
      if (len == 0) begin
         oa = 0; ob = 0; oc = 0;
         return 0;
      end
      oa = (a * ONE) / len;
      ob = (b * ONE) / len;
      oc = (c * ONE) / len;
      return 1;
   endfunction

   function automatic void sin_cos(input longint ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit flip;
      z = ang <<< ANG_SHIFT;
      x = CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (z > ANG_RIGHT) begin
         z = z - ANG_HALF; flip = 1;
      end else if (z < -ANG_RIGHT) begin
         z = z + ANG_HALF; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(atan_deg(5'(i)));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(atan_deg(5'(i)));
         end
         x = nx;
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = x >>> VEC_SHIFT;
      s = y >>> VEC_SHIFT;
   endfunction

   function automatic longint wrap_angle(input longint a);
      while (a < -180 * ONE) a = a + 360 * ONE;
      while (a > 180 * ONE) a = a - 360 * ONE;
      return a;
   endfunction

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic pose_type update_pose(input logic [31:0] d, input logic [2:0] u);
      logic [1:0] op, dir, plane;
      logic rot, scaled;
      longint amt, travel, p, dd, cp, sp, cy, sy;
      longint m[3], uv[3], cr[3];
      pose_type r;
      bit ok;
      op = u[1:0];
      scaled = u[2];
      dir = d[1:0];
      plane = d[3:2];
      rot = d[4];
      amt = longint'($signed(d[29:5]));
      travel = scaled ? ((amt * speed_r) >>> FRAC_BITS) : amt;
      m = '{0, 0, 0};
      if (op == OP_ROT) begin
         if (!rot) begin
            p = pitch_r + amt;
            if (lock_r != 0) begin
               if (p > 89 * ONE) p = 89 * ONE;
               if (p < -89 * ONE) p = -89 * ONE;
            end
            pitch_r = wrap_angle(p);
         end else begin
            yaw_r = wrap_angle(yaw_r + amt);
         end
         sin_cos(pitch_r, cp, sp);
         sin_cos(yaw_r, cy, sy);
         ok = unit_vec((cp * cy) >>> FRAC_BITS, sp, (cp * sy) >>> FRAC_BITS,
                       fwd_v[0], fwd_v[1], fwd_v[2]);
         if (!ok) fwd_v = '{ONE, 0, 0};
      end else if (op == OP_AXIS) begin
         if (dir < 3) m[dir] = travel;
      end else begin
         dd = (dir == DIR_BACK || dir == DIR_LEFT) ? -travel : travel;
         if (dir < 2) begin
            uv = fwd_v;
         end else begin
            cr[0] = (fwd_v[1] * up_v[2] - fwd_v[2] * up_v[1]) >>> FRAC_BITS;
            cr[1] = (fwd_v[2] * up_v[0] - fwd_v[0] * up_v[2]) >>> FRAC_BITS;
            cr[2] = (fwd_v[0] * up_v[1] - fwd_v[1] * up_v[0]) >>> FRAC_BITS;
            ok = unit_vec(cr[0], cr[1], cr[2], uv[0], uv[1], uv[2]);
         end
         for (int i = 0; i < 3; i++) m[i] = (uv[i] * dd) >>> FRAC_BITS;
         if (op == OP_PLANE && plane < 3) m[plane] = 0;
      end
      for (int i = 0; i < 3; i++) pos_v[i] = sat32(pos_v[i] + m[i]);
      r.px = pos_v[0][31:0];
      r.py = pos_v[1][31:0];
      r.pz = pos_v[2][31:0];
      r.fx = fwd_v[0][17:0];
      r.fy = fwd_v[1][17:0];
      r.fz = fwd_v[2][17:0];
      r.pitch = pitch_r[24:0];
      r.yaw = yaw_r[24:0];
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic compare_field(input string what, input longint got, input longint want);
      if (got != want) report(what, got, want);
   endtask

   initial begin
      fail_count = 0;
      checked = 0;
   end

   assign pending = pose_q.size();

   always @(posedge clock) begin
      pose_type e;
      if (reset) begin
         pose_q.delete();
         speed_r = 163840;
         lock_r = 1;
         up_v = '{0, 65536, 0};
         pos_v = '{0, 0, 0};
         fwd_v = '{ONE, 0, 0};
         pitch_r = 0;
         yaw_r = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pose_q.size() == 0) begin
               report("unexpected transaction", 0, 0);
            end else begin
               e = pose_q.pop_front();
               checked++;
               compare_field("pos_x", $signed(rsp_tdata[31:0]), e.px);
               compare_field("pos_y", $signed(rsp_tdata[63:32]), e.py);
               compare_field("pos_z", $signed(rsp_tdata[95:64]), e.pz);
               compare_field("front_x", $signed(rsp_tdata[113:96]), e.fx);
               compare_field("front_y", $signed(rsp_tdata[131:114]), e.fy);
               compare_field("front_z", $signed(rsp_tdata[149:132]), e.fz);
               compare_field("pitch_deg", $signed(rsp_tdata[174:150]), e.pitch);
               compare_field("yaw_deg", $signed(rsp_tdata[199:175]), e.yaw);
            end
         end
         if (csr_we) begin
            case (csr_addr)
               REG_SPEED: speed_r = csr_wdata;
               REG_LOCK:  lock_r = csr_wdata[0];
               REG_UP_X:  up_v[0] = $signed(csr_wdata[17:0]);
               REG_UP_Y:  up_v[1] = $signed(csr_wdata[17:0]);
               REG_UP_Z:  up_v[2] = $signed(csr_wdata[17:0]);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pose_q.insert(pose_q.size(), update_pose(req_tdata, req_tuser));
         end
      end
   end

endmodule

FILE: sim/camera_pose_update_top_tb.sv
module camera_pose_update_top_tb;
   import cpose_pkg::*;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;
   localparam logic ROT_PITCH = 1'b0;
   localparam logic ROT_YAW = 1'b1;
   localparam int AMT_MAX = 16777215;
   localparam int AMT_MIN = -16777216;
   localparam int ONE_DEG = 65536;

   logic         clock;
   logic         reset;
   logic [31:0]  req_tdata;
   logic [2:0]   req_tuser;
   logic         req_tvalid;
   logic         req_tready;
   logic [199:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [22:0]  csr_wdata;
   int fail_count, pending, checked;
   int idle_pct, stall_pct;
   int sent;

   camera_pose_update_top dut (.*);

   camera_pose_update_checker chk (
      .clock, .reset, .req_tdata, .req_tuser, .req_tvalid, .req_tready,
      .rsp_tdata, .rsp_tvalid, .rsp_tready, .csr_we, .csr_addr, .csr_wdata,
      .fail_count, .pending, .checked
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= stall_pct);
   end

   task automatic csr_write(input logic [2:0] addr, input logic [22:0] data);
      csr_we = 1;
      csr_addr = addr;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic send(input logic [1:0] op, dir, plane, input logic rot, scaled,
                       input int amt);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tdata = {2'b00, amt[24:0], rot, plane, dir};
      req_tuser = {scaled, op};
      req_tvalid = 1;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 0;
      while (pending != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic random_items(input int n);
      int amt, sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(9);
         if (sel < 2) amt = $signed($urandom) >>> 7;
         else if (sel < 6) amt = $urandom_range(20 * ONE_DEG) - 10 * ONE_DEG;
         else amt = $urandom_range(400 * ONE_DEG) - 200 * ONE_DEG;
         send($urandom_range(3), $urandom_range(3), $urandom_range(3),
              $urandom_range(1), $urandom_range(1), amt);
      end
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      csr_we = 0;
      csr_addr = 0;
      csr_wdata = 0;
      rsp_tready = 0;
      idle_pct = 0;
      stall_pct = 0;
      sent = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, each command kind, clamps, wraps, saturation
      send(OP_AXIS, AXIS_X, AXIS_X, ROT_PITCH, 0, AMT_MAX);
      send(OP_AXIS, AXIS_Y, AXIS_X, ROT_PITCH, 0, AMT_MIN);
      send(OP_AXIS, AXIS_Z, AXIS_X, ROT_PITCH, 1, ONE_DEG);
      send(OP_AXIS, AXIS_NONE, AXIS_X, ROT_PITCH, 1, AMT_MAX);
      send(OP_REL, DIR_FWD, AXIS_X, ROT_PITCH, 1, 3 * ONE_DEG);
      send(OP_REL, DIR_BACK, AXIS_X, ROT_PITCH, 0, ONE_DEG);
      send(OP_REL, DIR_LEFT, AXIS_X, ROT_PITCH, 0, AMT_MAX);
      send(OP_REL, DIR_RIGHT, AXIS_X, ROT_PITCH, 1, AMT_MIN);
      send(OP_ROT, DIR_FWD, AXIS_X, ROT_PITCH, 1, 120 * ONE_DEG);
      send(OP_ROT, DIR_FWD, AXIS_X, ROT_PITCH, 0, AMT_MIN);
      send(OP_ROT, DIR_FWD, AXIS_X, ROT_YAW, 0, 170 * ONE_DEG);
      send(OP_ROT, DIR_FWD, AXIS_X, ROT_YAW, 0, 30 * ONE_DEG);
      send(OP_ROT, DIR_FWD, AXIS_X, ROT_YAW, 0, AMT_MIN);
      send(OP_PLANE, DIR_FWD, AXIS_X, ROT_PITCH, 0, AMT_MAX);
      send(OP_PLANE, DIR_BACK, AXIS_Y, ROT_PITCH, 1, AMT_MAX);
      send(OP_PLANE, DIR_LEFT, AXIS_Z, ROT_PITCH, 0, AMT_MIN);
      send(OP_PLANE, DIR_RIGHT, AXIS_NONE, ROT_PITCH, 1, AMT_MAX);
      drain();
      csr_write(REG_SPEED, 23'd6553600);
      csr_write(REG_LOCK, 23'd0);
      send(OP_AXIS, AXIS_X, AXIS_X, ROT_PITCH, 1, AMT_MAX);
      send(OP_AXIS, AXIS_X, AXIS_X, ROT_PITCH, 1, AMT_MAX);
      send(OP_AXIS, AXIS_Z, AXIS_X, ROT_PITCH, 1, AMT_MIN);
      send(OP_AXIS, AXIS_Z, AXIS_X, ROT_PITCH, 1, AMT_MIN);
      send(OP_ROT, DIR_FWD, AXIS_X, ROT_PITCH, 0, 90 * ONE_DEG);
      send(OP_REL, DIR_LEFT, AXIS_X, ROT_PITCH, 0, 5 * ONE_DEG);
      send(OP_ROT, DIR_FWD, AXIS_X, ROT_PITCH, 0, AMT_MAX);

      // random phases with different settings and traffic shapes
      idle_pct = 0; stall_pct = 0;
      random_items(320);
      drain();
      csr_write(REG_SPEED, 23'd0);
      csr_write(REG_LOCK, 23'd1);
      csr_write(REG_UP_X, 23'h30000);
      csr_write(REG_UP_Y, 23'd0);
      csr_write(REG_UP_Z, 23'd65536);
      idle_pct = 72; stall_pct = 0;
      random_items(320);
      drain();
      csr_write(REG_SPEED, 23'd65536);
      csr_write(REG_UP_X, 23'd0);
      csr_write(REG_UP_Z, 23'd0);
      idle_pct = 0; stall_pct = 72;
      random_items(320);
      drain();
      csr_write(REG_SPEED, $urandom_range(6553600));
      csr_write(REG_LOCK, 23'd0);
      csr_write(REG_UP_X, 23'd46341);
      csr_write(REG_UP_Y, 23'h30000);
      csr_write(REG_UP_Z, 23'h3_4AFB);
      idle_pct = 30; stall_pct = 30;
      random_items(320);
      drain();

      $display("sent %0d commands over five register settings, %0d poses checked",
               sent, checked);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
